// File: hw/rtl/sixteen_bit_risc_executor_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sixteen-bit RISC executor
// Clocked property checks used by the top-level RTL file of the block.
// ---------------------------------------------------------------------------
`ifndef SIXTEEN_BIT_RISC_EXECUTOR_TOP_ASSERT_SVH
`define SIXTEEN_BIT_RISC_EXECUTOR_TOP_ASSERT_SVH

// Check that holds outside reset
`define SBRX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds at every edge, reset included
`define SBRX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/sbrx_pkg.sv
// ---------------------------------------------------------------------------
// sbrx_pkg
// Types, sizes and instruction codes of the sixteen-bit RISC executor.
// ---------------------------------------------------------------------------
package sbrx_pkg;

  // Main memory size; must be a power of two between 1024 and 8192
  localparam int MEM_DEPTH = 8192;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int REG_COUNT = 8;
  localparam int REG_AW    = $clog2(REG_COUNT);
  localparam int WORD_W    = 16;
  localparam int ADDR_W    = 13;

  // Commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Opcodes, bits 15..13
  localparam logic [2:0] OP_RTYPE = 3'd0;
  localparam logic [2:0] OP_ADDI  = 3'd1;
  localparam logic [2:0] OP_J     = 3'd2;
  localparam logic [2:0] OP_JAL   = 3'd3;
  localparam logic [2:0] OP_LW    = 3'd4;
  localparam logic [2:0] OP_SW    = 3'd5;
  localparam logic [2:0] OP_JEQ   = 3'd6;
  localparam logic [2:0] OP_SLTI  = 3'd7;

  // Function codes of the register-register group
  localparam logic [3:0] FN_ADD = 4'd0;
  localparam logic [3:0] FN_SUB = 4'd1;
  localparam logic [3:0] FN_AND = 4'd2;
  localparam logic [3:0] FN_OR  = 4'd3;
  localparam logic [3:0] FN_SLT = 4'd4;
  localparam logic [3:0] FN_JR  = 4'd8;

  // Link register of jal
  localparam logic [REG_AW-1:0] LINK_REG = REG_AW'(7);

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] load_address;
    logic [WORD_W-1:0] load_word;
  } in_req_t;

  typedef struct packed {
    logic              [WORD_W-1:0] program_counter;
    logic                           halted;
    logic                           reg_write_valid;
    logic              [2:0]        reg_index;
    logic              [WORD_W-1:0] reg_value;
    logic                           mem_write_valid;
    logic              [ADDR_W-1:0] mem_address;
    logic              [WORD_W-1:0] mem_value;
  } out_req_t;

  // Outcome of one executed instruction
  typedef struct packed {
    logic              reg_we;
    logic [REG_AW-1:0] reg_dst;
    logic [WORD_W-1:0] reg_val;
    logic              is_load;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [WORD_W-1:0] mem_val;
    logic [WORD_W-1:0] next_pc;
    logic              halt;
  } exec_res_t;

endpackage

// File: hw/rtl/sbrx_alu.sv
// ---------------------------------------------------------------------------
// sbrx_alu
// Decode and execute stage: from the instruction word, both operands and
// the pc, works out the register write, memory access, next pc and halt.
// ---------------------------------------------------------------------------
module sbrx_alu (
  input  logic [sbrx_pkg::WORD_W-1:0] ir,
  input  logic [sbrx_pkg::WORD_W-1:0] op_a,
  input  logic [sbrx_pkg::WORD_W-1:0] op_b,
  input  logic [sbrx_pkg::WORD_W-1:0] pc,
  output sbrx_pkg::exec_res_t         res
);
  import sbrx_pkg::*;

  logic [2:0]        opcode;
  logic [3:0]        funct;
  logic [REG_AW-1:0] rb, rc;
  logic [WORD_W-1:0] imm, target, pc_inc, addr_sum;
  logic              wr, jump;
  logic              is_ld, st_we;
  logic [REG_AW-1:0] dest;
  logic [WORD_W-1:0] val, nxt;

  assign opcode   = ir[15:13];
  assign funct    = ir[3:0];
  assign rb       = ir[9:7];
  assign rc       = ir[6:4];
  assign imm      = {{(WORD_W-7){ir[6]}}, ir[6:0]};
  assign target   = WORD_W'(ir[12:0]);
  assign pc_inc   = pc + WORD_W'(1);
  assign addr_sum = op_a + imm;

  // Instruction decode
  always_comb begin
    wr    = 1'b0;
    jump  = 1'b0;
    dest  = '0;
    val   = '0;
    nxt   = pc_inc;
    is_ld = 1'b0;
    st_we = 1'b0;
    unique case (opcode)
      OP_RTYPE: begin
        unique case (funct)
          FN_ADD: begin wr = 1'b1; dest = rc; val = op_a + op_b; end
          FN_SUB: begin wr = 1'b1; dest = rc; val = op_a - op_b; end
          FN_AND: begin wr = 1'b1; dest = rc; val = op_a & op_b; end
          FN_OR:  begin wr = 1'b1; dest = rc; val = op_a | op_b; end
          FN_SLT: begin wr = 1'b1; dest = rc; val = WORD_W'(op_a < op_b); end
          FN_JR:  begin jump = 1'b1; nxt = op_a; end
          default: ;
        endcase
      end
      OP_ADDI: begin wr = 1'b1; dest = rb; val = addr_sum; end
      OP_J:    begin jump = 1'b1; nxt = target; end
      OP_JAL: begin
        wr = 1'b1; dest = LINK_REG; val = pc_inc;
        jump = 1'b1; nxt = target;
      end
      OP_LW: begin
        wr = 1'b1; dest = rb;
        is_ld = 1'b1;
      end
      OP_SW:   st_we = 1'b1;
      OP_JEQ: begin
        jump = 1'b1;
        if (op_a == op_b) nxt = pc_inc + imm;
      end
      OP_SLTI: begin wr = 1'b1; dest = rb; val = WORD_W'(op_a < imm); end
      default: ;
    endcase
  end

  assign res.reg_we   = wr && (dest != '0);
  assign res.reg_dst  = dest;
  assign res.reg_val  = val;
  assign res.is_load  = is_ld;
  assign res.mem_we   = st_we;
  assign res.mem_addr = addr_sum[MEM_AW-1:0];
  assign res.mem_val  = op_b;
  assign res.next_pc  = nxt;
  // jump onto itself stops the machine
  assign res.halt     = jump && (nxt == pc);

endmodule

// File: hw/rtl/sixteen_bit_risc_executor_top.sv
// ---------------------------------------------------------------------------
// sixteen_bit_risc_executor_top
// Sixteen-bit eight-register processor: load and step commands in, one
// status report per command out.
// ---------------------------------------------------------------------------
// After reset the block clears main memory and the register file, one word
// a cycle, and stalls its input until that pass ends. A load command, or a
// step once halted, is reported straight from the idle state. A step runs
// through instruction fetch from the synchronous main memory, operand read
// from the register file memory, then execute and writeback; lw adds a
// data read on the same single memory port and a writeback state. One
// command is in work at a time, and a new one is taken only when the result
// slot is free or being emptied.
module sixteen_bit_risc_executor_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sbrx_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output sbrx_pkg::out_req_t out_req
);
  import sbrx_pkg::*;
  `include "sixteen_bit_risc_executor_top_assert.svh"

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_WB    = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [MEM_AW-1:0] clr_cnt_r;
  logic [WORD_W-1:0] pc_r, pc_nxt;
  logic              halt_r, halt_nxt;
  logic [WORD_W-1:0] ir_r, a_r, b_r;
  logic              out_valid_r;
  out_req_t          out_r, out_nxt;
  logic              out_load;

  logic              in_acc, out_free;
  exec_res_t         ex;

  // Main memory and register file
  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic [WORD_W-1:0] mem_rdata_r;
  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [WORD_W-1:0] rf [REG_COUNT];
  logic              rf_we;
  logic [REG_AW-1:0] rf_waddr;
  logic [WORD_W-1:0] rf_wdata;

  // Handshakes
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_req   = out_r;

  sbrx_alu u_alu (
    .ir   (ir_r),
    .op_a (a_r),
    .op_b (b_r),
    .pc   (pc_r),
    .res  (ex)
  );

  // Main memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_req.load_address[MEM_AW-1:0];
    mem_wdata = in_req.load_word;
    mem_re    = 1'b0;
    mem_raddr = pc_r[MEM_AW-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        if (in_acc && in_req.command == CMD_LOAD) mem_we = 1'b1;
        if (in_acc && in_req.command == CMD_STEP && !halt_r) mem_re = 1'b1;
      end
      ST_EXEC: begin
        mem_raddr = ex.mem_addr;
        mem_waddr = ex.mem_addr;
        mem_wdata = ex.mem_val;
        mem_re    = ex.is_load;
        mem_we    = ex.mem_we && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= mem[mem_raddr];
  end

  // Register file write port
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = ex.reg_dst;
    rf_wdata = ex.reg_val;
    unique case (state_r)
      ST_CLEAR: begin
        rf_we    = clr_cnt_r < MEM_AW'(REG_COUNT);
        rf_waddr = clr_cnt_r[REG_AW-1:0];
        rf_wdata = '0;
      end
      ST_EXEC:  rf_we = ex.reg_we && !ex.is_load && out_free;
      ST_WB: begin
        rf_waddr = ir_r[9:7];
        rf_wdata = mem_rdata_r;
        rf_we    = (ir_r[9:7] != '0) && out_free;
      end
      default: ;
    endcase
  end

  // Register file: one write, two registered reads of the fetched fields
  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_waddr] <= rf_wdata;
    if (state_r == ST_FETCH) begin
      ir_r <= mem_rdata_r;
      a_r  <= rf[mem_rdata_r[12:10]];
      b_r  <= rf[mem_rdata_r[9:7]];
    end
  end

  // Sequencer, pc and result
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    halt_nxt  = halt_r;
    out_load  = 1'b0;
    out_nxt   = '0;
    out_nxt.program_counter = pc_r;
    out_nxt.halted          = halt_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == MEM_AW'(MEM_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req.command == CMD_LOAD) begin
            out_load = 1'b1;
            out_nxt.mem_write_valid = 1'b1;
            out_nxt.mem_address     = ADDR_W'(in_req.load_address[MEM_AW-1:0]);
            out_nxt.mem_value       = in_req.load_word;
          end else if (halt_r) begin
            out_load = 1'b1;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (ex.is_load) begin
          state_nxt = ST_WB;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
          pc_nxt    = ex.next_pc;
          halt_nxt  = ex.halt;
          out_load  = 1'b1;
          out_nxt.program_counter = ex.next_pc;
          out_nxt.halted          = ex.halt;
          out_nxt.reg_write_valid = ex.reg_we;
          out_nxt.reg_index       = ex.reg_we ? 3'(ex.reg_dst) : '0;
          out_nxt.reg_value       = ex.reg_we ? ex.reg_val : '0;
          out_nxt.mem_write_valid = ex.mem_we;
          out_nxt.mem_address     = ex.mem_we ? ADDR_W'(ex.mem_addr) : '0;
          out_nxt.mem_value       = ex.mem_we ? ex.mem_val : '0;
        end
      end
      ST_WB: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          pc_nxt    = pc_r + WORD_W'(1);
          out_load  = 1'b1;
          out_nxt.program_counter = pc_r + WORD_W'(1);
          out_nxt.reg_write_valid = ir_r[9:7] != '0;
          out_nxt.reg_index       = (ir_r[9:7] != '0) ? ir_r[9:7] : '0;
          out_nxt.reg_value       = (ir_r[9:7] != '0) ? mem_rdata_r : '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      halt_r  <= halt_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_r <= out_nxt;
  end

  // Checks
  `SBRX_ASSERT(a_step_fetches, (in_acc && in_req.command == CMD_STEP && !halt_r) |=> (state_r == ST_FETCH), "step did not start a fetch")
  `SBRX_ASSERT(a_load_reports, (in_acc && in_req.command == CMD_LOAD) |=> (out_valid_r && out_r.mem_write_valid), "load gave no memory write report")
  `SBRX_ASSERT(a_halt_sticks, !$fell(halt_r), "halt flag dropped outside reset")
  `SBRX_ASSERT(a_halt_pc_frozen, halt_r |=> $stable(pc_r), "pc moved while halted")
  `SBRX_ASSERT_ALWAYS(a_no_result_in_clear, (state_r == ST_CLEAR) |-> !out_load, "result produced during clearing pass")

endmodule

// File: bench/tb_sixteen_bit_risc_executor_top.sv
// ---------------------------------------------------------------------------
// tb_sixteen_bit_risc_executor_top
// Self-checking bench for the sixteen-bit RISC executor. Commands are
// queued up front, a driver sends them with random gaps, and a monitor
// takes the reports with random stalls. Each report is checked field by
// field against an in-bench model of the processor. A second copy of the
// model runs while the stimulus is built, so that programs stay clear of
// halting until the last phase.
// ---------------------------------------------------------------------------
module tb_sixteen_bit_risc_executor_top;
  import sbrx_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 850;

  // Model copies: one follows accepted requests, one follows the queue
  localparam int TRACK_ACCEPTED = 0;
  localparam int TRACK_QUEUED   = 1;

  typedef enum int {HALT_BY_JEQ, HALT_BY_J, HALT_BY_JAL, HALT_BY_JR} halt_route_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_req;

  sixteen_bit_risc_executor_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Processor state, one copy per track
  logic [WORD_W-1:0] mem_img  [2][MEM_DEPTH];
  logic [WORD_W-1:0] rf_img   [2][REG_COUNT];
  logic [WORD_W-1:0] pc_img   [2];
  logic              halt_img [2];

  in_req_t  pending_cmds[$];
  out_req_t expected_reports[$];

  int unsigned fail_count     = 0;
  int unsigned loads_accepted = 0;
  int unsigned steps_accepted = 0;
  int unsigned reports_seen   = 0;
  int unsigned cycle_count    = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  int unsigned drv_quiet      = 0;
  int unsigned mon_quiet      = 0;
  string       halt_note      = "";

  function automatic logic [ADDR_W-1:0] wrap_addr(logic [WORD_W-1:0] a);
    return ADDR_W'(a & WORD_W'(MEM_DEPTH - 1));
  endfunction

  // Apply one command to a model copy and return its report
  function automatic out_req_t execute_command(int cp, in_req_t it);
    out_req_t          r;
    logic [WORD_W-1:0] w, a, b, imm, nxt, val, pc;
    logic [2:0]        dst;
    logic [ADDR_W-1:0] ea;
    logic              wr, jmp;
    r = '0;
    if (it.command == CMD_LOAD) begin
      ea = wrap_addr(WORD_W'(it.load_address));
      mem_img[cp][ea] = it.load_word;
      r.mem_write_valid = 1'b1;
      r.mem_address = ea;
      r.mem_value = it.load_word;
    end else if (!halt_img[cp]) begin
      pc  = pc_img[cp];
      w   = mem_img[cp][wrap_addr(pc)];
      a   = rf_img[cp][w[12:10]];
      b   = rf_img[cp][w[9:7]];
      imm = {{9{w[6]}}, w[6:0]};
      nxt = pc + 16'd1;
      jmp = 1'b0;
      wr  = 1'b0;
      dst = '0;
      val = '0;
      case (w[15:13])
        OP_RTYPE: begin
          dst = w[6:4];
          case (w[3:0])
            FN_ADD: begin wr = 1'b1; val = a + b; end
            FN_SUB: begin wr = 1'b1; val = a - b; end
            FN_AND: begin wr = 1'b1; val = a & b; end
            FN_OR:  begin wr = 1'b1; val = a | b; end
            FN_SLT: begin wr = 1'b1; val = (a < b) ? 16'd1 : 16'd0; end
            FN_JR:  begin jmp = 1'b1; nxt = a; end
            default: ;
          endcase
        end
        OP_ADDI: begin wr = 1'b1; dst = w[9:7]; val = a + imm; end
        OP_J:    begin jmp = 1'b1; nxt = {3'b000, w[12:0]}; end
        OP_JAL: begin
          wr = 1'b1; dst = LINK_REG; val = pc + 16'd1;
          jmp = 1'b1; nxt = {3'b000, w[12:0]};
        end
        OP_LW: begin
          wr = 1'b1; dst = w[9:7];
          val = mem_img[cp][wrap_addr(a + imm)];
        end
        OP_SW: begin
          ea = wrap_addr(a + imm);
          mem_img[cp][ea] = b;
          r.mem_write_valid = 1'b1;
          r.mem_address = ea;
          r.mem_value = b;
        end
        OP_JEQ: begin
          jmp = 1'b1;
          if (a == b) nxt = pc + 16'd1 + imm;
        end
        default: begin wr = 1'b1; dst = w[9:7]; val = (a < imm) ? 16'd1 : 16'd0; end
      endcase
      if (wr && dst != 3'd0) begin
        rf_img[cp][dst] = val;
        r.reg_write_valid = 1'b1;
        r.reg_index = dst;
        r.reg_value = val;
      end
      if (jmp && nxt == pc) halt_img[cp] = 1'b1;
      pc_img[cp] = nxt;
    end
    r.program_counter = pc_img[cp];
    r.halted = halt_img[cp];
    return r;
  endfunction

  // Instruction encoders
  function automatic logic [15:0] enc_rr(logic [3:0] fn, logic [2:0] ra, logic [2:0] rb,
                                         logic [2:0] rc);
    return {OP_RTYPE, ra, rb, rc, fn};
  endfunction

  function automatic logic [15:0] enc_ri(logic [2:0] op, logic [2:0] ra, logic [2:0] rb,
                                         logic [6:0] imm);
    return {op, ra, rb, imm};
  endfunction

  function automatic in_req_t load_cmd(logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] word);
    in_req_t it;
    it.command = CMD_LOAD;
    it.load_address = addr;
    it.load_word = word;
    return it;
  endfunction

  // Random instruction, mostly with defined function codes
  function automatic logic [15:0] rand_instr();
    logic [15:0] w;
    w = 16'($urandom);
    w[15:13] = 3'($urandom_range(0, 7));
    if (w[15:13] == OP_RTYPE) begin
      case ($urandom_range(0, 6))
        0: w[3:0] = FN_ADD;
        1: w[3:0] = FN_SUB;
        2: w[3:0] = FN_AND;
        3: w[3:0] = FN_OR;
        4: w[3:0] = FN_SLT;
        5: w[3:0] = FN_JR;
        default: ;
      endcase
    end
    if (w[15:13] == OP_JEQ && $urandom_range(0, 1) == 1) w[9:7] = w[12:10];
    return w;
  endfunction

  // Random instruction that can never jump
  function automatic logic [15:0] plain_instr();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(0, 3))
      0: w[15:13] = OP_ADDI;
      1: w[15:13] = OP_LW;
      2: w[15:13] = OP_SW;
      default: w[15:13] = OP_SLTI;
    endcase
    return w;
  endfunction

  function automatic int unsigned next_wait(inout int unsigned quiet);
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  task automatic queue_cmd(in_req_t it);
    void'(execute_command(TRACK_QUEUED, it));
    pending_cmds.push_back(it);
  endtask

  // Queue a step; unless halting is wanted, patch a halting word first
  task automatic queue_step(bit allow_halt);
    in_req_t     st;
    logic [15:0] link_save;
    st.command = CMD_STEP;
    st.load_address = ADDR_W'($urandom);
    st.load_word = WORD_W'($urandom);
    link_save = rf_img[TRACK_QUEUED][LINK_REG];
    void'(execute_command(TRACK_QUEUED, st));
    if (halt_img[TRACK_QUEUED] && !allow_halt) begin
      halt_img[TRACK_QUEUED] = 1'b0;
      rf_img[TRACK_QUEUED][LINK_REG] = link_save;
      queue_cmd(load_cmd(wrap_addr(pc_img[TRACK_QUEUED]), plain_instr()));
      void'(execute_command(TRACK_QUEUED, st));
    end
    pending_cmds.push_back(st);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Build the whole command stream, then release reset and wait for the end
  initial begin
    int unsigned n, steps, k;
    halt_route_t route;
    logic [15:0] pc, word;
    logic [2:0]  ra;
    bit          found;
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < MEM_DEPTH; i++) mem_img[c][i] = '0;
      for (int i = 0; i < REG_COUNT; i++) rf_img[c][i] = '0;
      pc_img[c] = '0;
      halt_img[c] = 1'b0;
    end

    // Directed program: every operation, immediate extremes, address wrap,
    // a write to r0 and an unused function code
    queue_cmd(load_cmd(13'd0,  enc_ri(OP_ADDI, 3'd0, 3'd1, 7'h7F)));
    queue_cmd(load_cmd(13'd1,  enc_ri(OP_ADDI, 3'd0, 3'd2, 7'h3F)));
    queue_cmd(load_cmd(13'd2,  enc_rr(FN_ADD, 3'd1, 3'd2, 3'd3)));
    queue_cmd(load_cmd(13'd3,  enc_rr(FN_SUB, 3'd2, 3'd1, 3'd4)));
    queue_cmd(load_cmd(13'd4,  enc_rr(FN_AND, 3'd1, 3'd2, 3'd5)));
    queue_cmd(load_cmd(13'd5,  enc_rr(FN_OR,  3'd1, 3'd2, 3'd0)));
    queue_cmd(load_cmd(13'd6,  enc_rr(FN_SLT, 3'd2, 3'd1, 3'd6)));
    queue_cmd(load_cmd(13'd7,  enc_ri(OP_SLTI, 3'd2, 3'd7, 7'h7F)));
    queue_cmd(load_cmd(13'd8,  enc_ri(OP_SW, 3'd2, 3'd1, 7'h40)));
    queue_cmd(load_cmd(13'd9,  enc_ri(OP_LW, 3'd1, 3'd5, 7'h00)));
    queue_cmd(load_cmd(13'd10, enc_rr(4'hF, 3'd1, 3'd2, 3'd3)));
    queue_cmd(load_cmd(13'd11, {OP_JAL, 13'd13}));
    queue_cmd(load_cmd(13'd13, enc_ri(OP_JEQ, 3'd0, 3'd0, 7'd5)));
    queue_cmd(load_cmd(13'd19, enc_rr(FN_JR, 3'd4, 3'd0, 3'd0)));
    queue_cmd(load_cmd(13'd64, {OP_J, 13'd30}));
    for (k = 0; k < 15; k++) queue_step(1'b0);

    // Random programs written at the pc and then run, mixed with noise
    while (pending_cmds.size() < RANDOM_ITEMS + 30) begin
      if ($urandom_range(0, 3) != 0) begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++)
          queue_cmd(load_cmd(wrap_addr(pc_img[TRACK_QUEUED] + 16'(k)), rand_instr()));
        if ($urandom_range(0, 2) == 0)
          queue_cmd(load_cmd(wrap_addr(rf_img[TRACK_QUEUED][3'($urandom_range(0, 7))]
                                       + 16'($urandom_range(0, 127)) - 16'd64),
                             16'($urandom)));
        steps = n + $urandom_range(0, 2);
        for (k = 0; k < steps; k++) queue_step(1'b0);
      end else if ($urandom_range(0, 1) == 0) begin
        queue_cmd(load_cmd(ADDR_W'($urandom), WORD_W'($urandom)));
      end else begin
        queue_step(1'b0);
      end
    end

    // Closing phase: halt by one of the jump kinds, then poke the halted core
    pc = pc_img[TRACK_QUEUED];
    route = halt_route_t'($urandom_range(0, 3));
    ra = 3'($urandom_range(0, 7));
    word = enc_ri(OP_JEQ, ra, ra, 7'h7F);
    halt_note = "jeq";
    if ((route == HALT_BY_J || route == HALT_BY_JAL) && pc[15:13] == 3'b000) begin
      word = {(route == HALT_BY_J) ? OP_J : OP_JAL, pc[12:0]};
      halt_note = (route == HALT_BY_J) ? "j" : "jal";
    end else if (route == HALT_BY_JR) begin
      found = 1'b0;
      for (int i = 1; i < REG_COUNT; i++)
        if (!found && rf_img[TRACK_QUEUED][i] == pc) begin
          found = 1'b1;
          word = enc_rr(FN_JR, 3'(i), 3'd0, 3'd0);
          halt_note = "jr";
        end
    end
    queue_cmd(load_cmd(wrap_addr(pc), word));
    queue_step(1'b1);
    queue_step(1'b1);
    queue_cmd(load_cmd(ADDR_W'($urandom), WORD_W'($urandom)));
    queue_step(1'b1);
    queue_cmd(load_cmd(wrap_addr(pc), plain_instr()));
    queue_step(1'b1);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d reports: %0d loads, %0d steps, halted by %s, %0d field errors",
             reports_seen, loads_accepted, steps_accepted, halt_note, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Request driver: takes commands from the queue, random gap after each
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_reports.push_back(execute_command(TRACK_ACCEPTED, in_req));
        if (in_req.command == CMD_LOAD) loads_accepted++;
        else steps_accepted++;
        gap_left = next_wait(drv_quiet);
        if (gap_left == 0 && pending_cmds.size() != 0) in_req <= pending_cmds.pop_front();
        else in_valid <= 1'b0;
      end else if (!in_valid) begin
        if (gap_left > 1) begin
          gap_left--;
        end else if (pending_cmds.size() != 0) begin
          gap_left = 0;
          in_req <= pending_cmds.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Report monitor: checks each report, random stall after each
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected report, expected none, actual %h", $time, out_req);
        end else begin
          out_req_t want;
          want = expected_reports.pop_front();
          check_field("program_counter", want.program_counter, out_req.program_counter);
          check_field("halted",          16'(want.halted),     16'(out_req.halted));
          check_field("reg_write_valid", 16'(want.reg_write_valid),
                      16'(out_req.reg_write_valid));
          check_field("reg_index",       16'(want.reg_index),  16'(out_req.reg_index));
          check_field("reg_value",       want.reg_value,       out_req.reg_value);
          check_field("mem_write_valid", 16'(want.mem_write_valid),
                      16'(out_req.mem_write_valid));
          check_field("mem_address",     16'(want.mem_address), 16'(out_req.mem_address));
          check_field("mem_value",       want.mem_value,       out_req.mem_value);
        end
        stall_left = next_wait(mon_quiet);
        if (stall_left != 0) out_stall <= 1'b1;
      end else if (out_stall) begin
        if (stall_left > 1) begin
          stall_left--;
        end else begin
          stall_left = 0;
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Watchdog, covers the clearing pass after reset as well
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d reports still outstanding", $time, expected_reports.size());
      $display("tb: failure");
      $finish;
    end
  end

endmodule
